// ===== hw/rtl/mcspg_pkg.sv =====
// Servo pulse generator package: word types, mode codes, register indexes,
// channel state codes. No dependencies.
package mcspg_pkg;

    localparam int PULSE_W   = 16;
    localparam int REFRESH_W = 20;
    localparam int TICK_W    = 10;
    localparam int ACTIVE_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;
    localparam int COUNT_W   = 32;
    localparam int PROD_W    = COUNT_W + TICK_W;
    localparam int PINS_W    = 4;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_WRITE   = 3'd1;
    localparam logic [2:0] MODE_START   = 3'd2;
    localparam logic [2:0] MODE_STOP    = 3'd3;
    localparam logic [2:0] MODE_DEFAULT = 3'd4;
    localparam logic [2:0] MODE_STATUS  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PULSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE        = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_INIT     = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_ENABLED  = 3'd3,
        ST_DISABLED = 3'd4,
        ST_FAULT    = 3'd5,
        ST_UNKNOWN  = 3'd6
    } chan_state_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [2:0]         channel;
        logic [PULSE_W-1:0] pulse_us;
    } in_t;

    typedef struct packed {
        logic              accepted;
        logic [2:0]        status;
        logic [PINS_W-1:0] pin_levels;
    } out_t;

endpackage

// ===== hw/rtl/multi_channel_servo_pulse_generator_unit.sv =====
// Multi-channel servo pulse generator top level: channel bank, sequencer,
// shared count/multiply/compare unit. Depends on mcspg_pkg.
//
// Usage:
//   s_* channel: one word per operation (tick, write width, start, stop,
//   go default, status query). m_* channel: one result word per input word.
//   cfg_* channel: register writes, always ready; write only while idle.
// Sequence:
//   A non-tick word passes through S_OP and then S_DONE, which loads the
//   output reg; the next word is taken after that, back in S_IDLE.
//   A tick visits the live channels one at a time through one shared
//   increment / 32x10 multiply / compare unit, in the steps S_READ, S_MUL
//   and S_EVAL per channel; S_DONE then loads the result. Input is accepted
//   only in the idle state, so a word is finished before the next is taken.
// Reset: synchronous, active low; registers return to their defaults and
//   every channel goes idle with its pin low.
// Stall: a finished result waits in the output register; the next input word
//   is still taken and worked on, and its result waits until that register
//   frees up.
module multi_channel_servo_pulse_generator_unit #(
    parameter int CHANNELS = 4
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  mcspg_pkg::in_t                          s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output mcspg_pkg::out_t                         m_data,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mcspg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mcspg_pkg::CFG_DAT_W-1:0]         cfg_data
);
    import mcspg_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_READ,
        S_MUL,
        S_EVAL,
        S_DONE
    } seq_state_t;

    seq_state_t state_reg;

    logic [PULSE_W-1:0]   min_pulse_reg;
    logic [PULSE_W-1:0]   max_pulse_reg;
    logic [PULSE_W-1:0]   default_pulse_reg;
    logic [REFRESH_W-1:0] refresh_reg;
    logic [TICK_W-1:0]    tick_period_reg;
    logic [ACTIVE_W-1:0]  active_reg;

    chan_state_t          chan_state_reg [CHANNELS];
    logic [COUNT_W-1:0]   tick_count_reg [CHANNELS];
    logic [PULSE_W-1:0]   cur_width_reg  [CHANNELS];
    logic [PULSE_W-1:0]   des_width_reg  [CHANNELS];
    logic [CHANNELS-1:0]  pin_reg;

    logic [2:0]           mode_reg;
    logic [2:0]           ptr_reg;
    logic [PULSE_W-1:0]   pw_reg;
    logic                 acc_reg;
    chan_state_t          st_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 m_valid_reg;
    out_t                 m_data_reg;

    logic [ACTIVE_W-1:0]  live;
    logic [ADDR_W-1:0]    addr;
    logic                 ch_valid;
    logic [COUNT_W-1:0]   cnt_inc;
    logic [PULSE_W-1:0]   cw_rd;
    logic [PULSE_W-1:0]   dw_rd;
    logic [PINS_W-1:0]    pins_w;
    out_t                 result;

    chan_state_t          st_next;
    logic [COUNT_W-1:0]   cnt_next;
    logic [PULSE_W-1:0]   cw_next;
    logic                 pin_next;

    assign live = ({2'b00, active_reg} > 5'(CHANNELS)) ? ACTIVE_W'(CHANNELS) : active_reg;
    assign addr     = ADDR_W'(ptr_reg);
    assign ch_valid = ptr_reg < live;
    assign cnt_inc  = tick_count_reg[addr] + COUNT_W'(1);
    assign cw_rd    = cur_width_reg[addr];
    assign dw_rd    = des_width_reg[addr];

    for (genvar i = 0; i < PINS_W; i++) begin : g_pins
        if (i < CHANNELS) begin : g_on
            assign pins_w[i] = pin_reg[i];
        end else begin : g_off
            assign pins_w[i] = 1'b0;
        end
    end

    // per-channel tick update, fed by the registered count and product
    always_comb begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        cw_next  = cw_rd;
        pin_next = pin_reg[addr];
        unique case (st_reg)
            ST_IDLE: begin
                pin_next = 1'b0;
                cnt_next = '0;
            end
            ST_INIT: begin
                cw_next = dw_rd;
                if (dw_rd >= PULSE_W'(tick_period_reg)) begin
                    st_next = ST_UPDATED;
                end
            end
            ST_UPDATED: begin
                pin_next = 1'b1;
                cnt_next = '0;
                st_next  = ST_ENABLED;
            end
            ST_ENABLED: begin
                if (prod_reg >= PROD_W'(cw_rd)) begin
                    pin_next = 1'b0;
                    st_next  = ST_DISABLED;
                end
            end
            ST_DISABLED: begin
                if (prod_reg >= PROD_W'(refresh_reg)) begin
                    st_next = (cw_rd != dw_rd) ? ST_INIT : ST_UPDATED;
                end
            end
            default: begin
                cnt_next = '0;
                pin_next = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.accepted   = acc_reg;
        result.pin_levels = pins_w;
        if (mode_reg == MODE_TICK) begin
            result.status = ST_IDLE;
        end else if (ch_valid) begin
            result.status = chan_state_reg[addr];
        end else begin
            result.status = ST_UNKNOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            m_valid_reg       <= 1'b0;
            min_pulse_reg     <= PULSE_W'(1000);
            max_pulse_reg     <= PULSE_W'(2000);
            default_pulse_reg <= PULSE_W'(1500);
            refresh_reg       <= REFRESH_W'(20000);
            tick_period_reg   <= TICK_W'(50);
            active_reg        <= '0;
            pin_reg           <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                chan_state_reg[i] <= ST_IDLE;
                tick_count_reg[i] <= '0;
                cur_width_reg[i]  <= '0;
                des_width_reg[i]  <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MIN_PULSE:     min_pulse_reg     <= cfg_data[PULSE_W-1:0];
                    CFG_MAX_PULSE:     max_pulse_reg     <= cfg_data[PULSE_W-1:0];
                    CFG_DEFAULT_PULSE: default_pulse_reg <= cfg_data[PULSE_W-1:0];
                    CFG_REFRESH:       refresh_reg       <= cfg_data[REFRESH_W-1:0];
                    CFG_TICK_PERIOD:   tick_period_reg   <= cfg_data[TICK_W-1:0];
                    CFG_ACTIVE:        active_reg        <= cfg_data[ACTIVE_W-1:0];
                    default: ;
                endcase
            end

            // S_DONE drives the valid flag itself
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg <= s_data.mode;
                        pw_reg   <= s_data.pulse_us;
                        if (s_data.mode == MODE_TICK) begin
                            acc_reg <= 1'b1;
                            ptr_reg <= '0;
                            state_reg <= (live == '0) ? S_DONE : S_READ;
                        end else begin
                            acc_reg   <= 1'b0;
                            ptr_reg   <= s_data.channel;
                            state_reg <= S_OP;
                        end
                    end
                end
                S_OP: begin
                    if (ch_valid) begin
                        unique case (mode_reg)
                            MODE_WRITE: begin
                                if (pw_reg <= max_pulse_reg && pw_reg >= min_pulse_reg) begin
                                    des_width_reg[addr] <= pw_reg;
                                    acc_reg <= 1'b1;
                                end
                            end
                            MODE_START: begin
                                chan_state_reg[addr] <= ST_INIT;
                                acc_reg <= 1'b1;
                            end
                            MODE_STOP: begin
                                pin_reg[addr]        <= 1'b0;
                                chan_state_reg[addr] <= ST_IDLE;
                                acc_reg <= 1'b1;
                            end
                            MODE_DEFAULT: begin
                                des_width_reg[addr] <= default_pulse_reg;
                                acc_reg <= 1'b1;
                            end
                            MODE_STATUS: acc_reg <= 1'b1;
                            default: ;
                        endcase
                    end
                    state_reg <= S_DONE;
                end
                S_READ: begin
                    cnt_reg   <= cnt_inc;
                    st_reg    <= (cnt_inc == COUNT_LIMIT) ? ST_FAULT : chan_state_reg[addr];
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= PROD_W'(cnt_reg) * PROD_W'(tick_period_reg);
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    chan_state_reg[addr] <= st_next;
                    tick_count_reg[addr] <= cnt_next;
                    cur_width_reg[addr]  <= cw_next;
                    pin_reg[addr]        <= pin_next;
                    if (3'(ptr_reg + 3'd1) == live) begin
                        state_reg <= S_DONE;
                    end else begin
                        ptr_reg   <= 3'(ptr_reg + 3'd1);
                        state_reg <= S_READ;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= result;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== test/tb_top.sv =====
// Testbench for the servo pulse generator unit: directed and random operation
// words, each result checked field by field against a typed row or a bank predictor.
// Depends on mcspg_pkg and multi_channel_servo_pulse_generator_unit.
`timescale 1ns / 100ps

module tb_top;
    import mcspg_pkg::*;

    localparam int SERVO_CH      = 4;
    localparam int PHASE_WORDS   = 200;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 5000;

    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef struct {
        int unsigned lo;
        int unsigned hi;
        int unsigned dflt;
        int unsigned refresh;
        int unsigned tick;
        int unsigned live;
    } servo_setting_t;

    typedef struct {
        in_t  word;
        bit   typed;
        out_t want;
    } op_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // predictor state
    chan_state_t          ch_state [SERVO_CH];
    logic [COUNT_W-1:0]   ticks    [SERVO_CH];
    logic [PULSE_W-1:0]   cur_w    [SERVO_CH];
    logic [PULSE_W-1:0]   want_w   [SERVO_CH];
    logic                 pin      [SERVO_CH];
    logic [PULSE_W-1:0]   lim_lo_us;
    logic [PULSE_W-1:0]   lim_hi_us;
    logic [PULSE_W-1:0]   dflt_us;
    logic [REFRESH_W-1:0] refresh_us;
    logic [TICK_W-1:0]    tick_us;
    logic [ACTIVE_W-1:0]  live_cfg;

    out_t           reports_due [$];
    op_row_t        rows [$];
    servo_setting_t plan [6];
    servo_setting_t bench_setting;

    int fails;
    int n_words;
    int n_ticks;
    int n_settings;
    int n_checked;
    int quiet_cycles;
    bit no_idle;
    bit hold_sink;

    multi_channel_servo_pulse_generator_unit #(
        .CHANNELS(SERVO_CH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic void tick_channel(int i);
        logic [PROD_W-1:0] spent;
        ticks[i] = ticks[i] + 1;
        if (ticks[i] == COUNT_LIMIT) ch_state[i] = ST_FAULT;
        spent = PROD_W'(ticks[i]) * PROD_W'(tick_us);
        case (ch_state[i])
            ST_IDLE: begin
                pin[i]   = 1'b0;
                ticks[i] = '0;
            end
            ST_INIT: begin
                cur_w[i] = want_w[i];
                if (cur_w[i] >= PULSE_W'(tick_us) && tick_us <= TICK_W'(cur_w[i])
                        || 32'(cur_w[i]) >= 32'(tick_us))
                    ch_state[i] = ST_UPDATED;
            end
            ST_UPDATED: begin
                pin[i]      = 1'b1;
                ticks[i]    = '0;
                ch_state[i] = ST_ENABLED;
            end
            ST_ENABLED: begin
                if (spent >= PROD_W'(cur_w[i])) begin
                    pin[i]      = 1'b0;
                    ch_state[i] = ST_DISABLED;
                end
            end
            ST_DISABLED: begin
                if (spent >= PROD_W'(refresh_us))
                    ch_state[i] = (cur_w[i] != want_w[i]) ? ST_INIT : ST_UPDATED;
            end
            default: begin
                ticks[i] = '0;
                pin[i]   = 1'b0;
            end
        endcase
    endfunction

    function automatic out_t servo_op(in_t w);
        out_t r;
        int   live;
        live = (live_cfg > SERVO_CH) ? SERVO_CH : int'(live_cfg);
        r = '0;
        if (w.mode == MODE_TICK) begin
            for (int i = 0; i < live; i++) tick_channel(i);
            r.accepted = 1'b1;
        end else if (w.channel < live) begin
            case (w.mode)
                MODE_WRITE: begin
                    if (w.pulse_us <= lim_hi_us && w.pulse_us >= lim_lo_us) begin
                        want_w[w.channel] = w.pulse_us;
                        r.accepted = 1'b1;
                    end
                end
                MODE_START: begin
                    ch_state[w.channel] = ST_INIT;
                    r.accepted = 1'b1;
                end
                MODE_STOP: begin
                    pin[w.channel]      = 1'b0;
                    ch_state[w.channel] = ST_IDLE;
                    r.accepted = 1'b1;
                end
                MODE_DEFAULT: begin
                    want_w[w.channel] = dflt_us;
                    r.accepted = 1'b1;
                end
                MODE_STATUS: r.accepted = 1'b1;
                default: ;
            endcase
            r.status = ch_state[w.channel];
        end else begin
            r.status = ST_UNKNOWN;
        end
        for (int i = 0; i < SERVO_CH && i < PINS_W; i++) r.pin_levels[i] = pin[i];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, 3);
        if (r < 9) return $urandom_range(4, 8);
        return $urandom_range(16, 40);
    endfunction

    function automatic in_t pick_servo_word();
        in_t w;
        int  r;
        r = $urandom_range(0, 99);
        w.pulse_us = PULSE_W'($urandom);
        w.channel  = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7))
                                                 : 3'($urandom_range(0, 3));
        if (r < 48) begin
            w.mode = MODE_TICK;
        end else if (r < 64) begin
            w.mode = MODE_WRITE;
            case ($urandom_range(0, 5))
                0: w.pulse_us = lim_lo_us - 1'b1;
                1: w.pulse_us = lim_hi_us + 1'b1;
                2: w.pulse_us = lim_lo_us;
                3: w.pulse_us = lim_hi_us;
                4: ;
                default: w.pulse_us = PULSE_W'($urandom_range(lim_hi_us, lim_lo_us));
            endcase
        end else if (r < 74) begin
            w.mode = MODE_START;
        end else if (r < 79) begin
            w.mode = MODE_STOP;
        end else if (r < 85) begin
            w.mode = MODE_DEFAULT;
        end else if (r < 96) begin
            w.mode = MODE_STATUS;
        end else if (r < 98) begin
            w.mode = MODE_SPARE_6;
        end else begin
            w.mode = MODE_SPARE_7;
        end
        return w;
    endfunction

    task automatic send_word(in_t w, bit typed, out_t want);
        int   gap;
        out_t got;
        gap = (!no_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        got = servo_op(w);
        reports_due.push_back(typed ? want : got);
        n_words++;
        if (w.mode == MODE_TICK) n_ticks++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DAT_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MIN_PULSE:     lim_lo_us  = PULSE_W'(value);
            CFG_MAX_PULSE:     lim_hi_us  = PULSE_W'(value);
            CFG_DEFAULT_PULSE: dflt_us    = PULSE_W'(value);
            CFG_REFRESH:       refresh_us = REFRESH_W'(value);
            CFG_TICK_PERIOD:   tick_us    = TICK_W'(value);
            CFG_ACTIVE:        live_cfg   = ACTIVE_W'(value);
            default: ;
        endcase
    endtask

    task automatic load_setting(servo_setting_t s);
        cfg_write(CFG_MIN_PULSE, s.lo);
        cfg_write(CFG_MAX_PULSE, s.hi);
        cfg_write(CFG_DEFAULT_PULSE, s.dflt);
        cfg_write(CFG_REFRESH, s.refresh);
        cfg_write(CFG_TICK_PERIOD, s.tick);
        cfg_write(CFG_ACTIVE, s.live);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic add_row(logic [2:0] mode, logic [2:0] ch, logic [PULSE_W-1:0] pw,
                           bit typed = 1'b0, logic acc = 1'b0,
                           logic [2:0] st = ST_IDLE, logic [PINS_W-1:0] pins = '0);
        op_row_t r;
        r.word.mode          = mode;
        r.word.channel       = ch;
        r.word.pulse_us      = pw;
        r.typed              = typed;
        r.want.accepted      = acc;
        r.want.status        = st;
        r.want.pin_levels    = pins;
        rows.push_back(r);
    endtask

    task automatic run_rows();
        foreach (rows[k]) send_word(rows[k].word, rows[k].typed, rows[k].want);
        settle();
        rows.delete();
    endtask

    // result sink: short random stalls, the odd long one, and a forced hold
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                hold_sink  = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : report_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reports_due.size() == 0) begin
                $error("result word with nothing expected: %h", m_data);
                fails++;
            end else begin
                want = reports_due.pop_front();
                n_checked++;
                if (m_data.accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, m_data.accepted);
                    fails++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    fails++;
                end
                if (m_data.pin_levels !== want.pin_levels) begin
                    $error("pin_levels: expected %b, got %b",
                           want.pin_levels, m_data.pin_levels);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        fails = 0; n_words = 0; n_ticks = 0; n_settings = 0; n_checked = 0;
        quiet_cycles = 0;
        no_idle   = 1'b0;
        hold_sink = 1'b0;

        lim_lo_us  = 16'd1000;
        lim_hi_us  = 16'd2000;
        dflt_us    = 16'd1500;
        refresh_us = 20'd20000;
        tick_us    = 10'd50;
        live_cfg   = '0;
        for (int i = 0; i < SERVO_CH; i++) begin
            ch_state[i] = ST_IDLE;
            ticks[i]    = '0;
            cur_w[i]    = '0;
            want_w[i]   = '0;
            pin[i]      = 1'b0;
        end

        bench_setting = '{100, 1000, 300, 1000, 100, 7};
        plan[0] = '{100, 800, 400, 1200, 100, 4};
        plan[1] = '{0, 65535, 65535, 0, 1000, 2};
        plan[2] = '{0, 300, 0, 0, 0, 3};
        plan[3] = '{65535, 65535, 5, 1048575, 1, 1};
        plan[4] = '{2000, 0, 50, 300, 50, 5};
        plan[5] = '{1, 4000, 1023, 3000, 1023, 7};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: no channel in use yet
        add_row(MODE_TICK, 0, 0, 1, 1, ST_IDLE, 0);
        add_row(MODE_STATUS, 0, 0, 1, 0, ST_UNKNOWN, 0);
        add_row(MODE_WRITE, 0, 1500, 1, 0, ST_UNKNOWN, 0);
        add_row(MODE_START, 3, 0, 1, 0, ST_UNKNOWN, 0);
        add_row(MODE_SPARE_7, 0, 16'hFFFF, 1, 0, ST_UNKNOWN, 0);
        run_rows();

        // active count above the bank size, width limits at their edges
        load_setting(bench_setting);
        add_row(MODE_WRITE, 0, 99, 1, 0, ST_IDLE, 0);
        add_row(MODE_WRITE, 0, 1001, 1, 0, ST_IDLE, 0);
        add_row(MODE_WRITE, 0, 100, 1, 1, ST_IDLE, 0);
        add_row(MODE_WRITE, 1, 1000, 1, 1, ST_IDLE, 0);
        add_row(MODE_DEFAULT, 2, 0, 1, 1, ST_IDLE, 0);
        add_row(MODE_WRITE, 7, 500, 1, 0, ST_UNKNOWN, 0);
        add_row(MODE_WRITE, 0, 16'hFFFF, 1, 0, ST_IDLE, 0);
        add_row(MODE_START, 0, 0, 1, 1, ST_INIT, 0);
        add_row(MODE_START, 1, 0, 1, 1, ST_INIT, 0);
        add_row(MODE_START, 2, 0, 1, 1, ST_INIT, 0);
        add_row(MODE_START, 3, 0, 1, 1, ST_INIT, 0);
        add_row(MODE_TICK, 0, 0);
        add_row(MODE_TICK, 5, 16'hFFFF);
        add_row(MODE_STATUS, 0, 0);
        add_row(MODE_TICK, 0, 0);
        add_row(MODE_STATUS, 3, 0);
        add_row(MODE_SPARE_6, 1, 0);
        add_row(MODE_WRITE, 0, 500);
        add_row(MODE_TICK, 0, 0);
        add_row(MODE_STOP, 1, 0);
        add_row(MODE_SPARE_7, 5, 16'hFFFF);
        add_row(MODE_STATUS, 4, 0);
        run_rows();

        foreach (plan[p]) begin
            load_setting(plan[p]);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                no_idle = (k % 100) < 20;
                if (k == 40) hold_sink = 1'b1;
                if (k == 130) settle();
                send_word(pick_servo_word(), 1'b0, '0);
            end
            settle();
        end

        $display("%0d operation words (%0d ticks) over %0d register settings, %0d results compared",
                 n_words, n_ticks, n_settings, n_checked);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mcspg_pkg.sv
hw/rtl/multi_channel_servo_pulse_generator_unit.sv
test/tb_top.sv
